// File: design/obbot_pkg.sv
package obbot_pkg;

  // Default coordinate width; each corner carries x and z at this width.
  localparam int unsigned COORD_WIDTH = 16;

  // Corners per transaction: four for each rectangle.
  localparam int unsigned NUM_CORNERS = 8;

  // Result tdata: overlap in bit 0, zero fill up to one byte.
  localparam int unsigned OUT_TDATA_WIDTH = 8;

  // Pipeline depth from input acceptance to result register.
  localparam int unsigned NUM_STAGES = 4;

endpackage

// File: design/obb_overlap_test_2d.sv
// Overlap test for two oriented rectangles in the plane (separating axis test).
//
// Input channel (in_*): one transaction carries both rectangles, eight corners
// of 2*COORD_WIDTH bits each, x in the low half and z in the high half, both
// signed. Result channel (out_*): one transaction per input, overlap in bit 0.
//
// The datapath is a four-stage pipeline: edges and center offset, the 24
// exact products, the dot-product magnitudes, then the four axis compares.
// One rectangle pair is taken per cycle while out_tready keeps the pipeline
// moving; the multiplier stage is the longest path.
//
// Each stage advances when the stage after it is empty or moving, so bubbles
// collapse and in_tready stays high while a result waits, until all four
// stages hold data and the receiver keeps out_tready low. Results leave in
// input order.
//
// Reset (rst_n low, synchronous) empties the pipeline; nothing else is kept
// between transactions.
module obb_overlap_test_2d #(
  parameter int unsigned COORD_WIDTH = obbot_pkg::COORD_WIDTH
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_tvalid,
  output logic in_tready,
  // r1_corner_a, r1_corner_b, r1_corner_c, r1_corner_d,
  // r2_corner_a, r2_corner_b, r2_corner_c, r2_corner_d (lowest first)
  input  logic [obbot_pkg::NUM_CORNERS*2*COORD_WIDTH-1:0] in_tdata,

  output logic out_tvalid,
  input  logic out_tready,
  // overlap
  output logic [obbot_pkg::OUT_TDATA_WIDTH-1:0] out_tdata
);

  localparam int unsigned NS       = obbot_pkg::NUM_STAGES;
  localparam int unsigned NC       = obbot_pkg::NUM_CORNERS;
  localparam int unsigned CORNER_W = 2 * COORD_WIDTH;
  localparam int unsigned EW       = COORD_WIDTH + 1;  // edge component
  localparam int unsigned DW       = COORD_WIDTH + 2;  // doubled center offset
  localparam int unsigned PW       = EW + DW;          // product
  localparam int unsigned DTW      = PW + 1;           // dot product
  localparam int unsigned SW       = DTW + 2;          // right-hand sum

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        vld_nxt[k] = rdy[k] ? in_tvalid : vld_r[k];
      end else begin
        vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NS-1];

  // ---------------------------------------------------------------------------
  // Stage 1: edges u = A1-B1, w = A1-D1, f = A2-B2, g = A2-D2 and
  // d = (A2+C2) - (A1+C1)
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] cx [NC];
  logic signed [COORD_WIDTH-1:0] cz [NC];

  for (genvar n = 0; n < NC; n++) begin : g_corner
    assign cx[n] = in_tdata[n*CORNER_W +: COORD_WIDTH];
    assign cz[n] = in_tdata[n*CORNER_W + COORD_WIDTH +: COORD_WIDTH];
  end

  logic signed [EW-1:0] ex_nxt [4];
  logic signed [EW-1:0] ez_nxt [4];
  logic signed [DW-1:0] dx_nxt, dz_nxt;
  logic signed [EW-1:0] ex_r [4];
  logic signed [EW-1:0] ez_r [4];
  logic signed [DW-1:0] dx_r, dz_r;

  always_comb begin
    ex_nxt[0] = EW'(cx[0]) - EW'(cx[1]);
    ez_nxt[0] = EW'(cz[0]) - EW'(cz[1]);
    ex_nxt[1] = EW'(cx[0]) - EW'(cx[3]);
    ez_nxt[1] = EW'(cz[0]) - EW'(cz[3]);
    ex_nxt[2] = EW'(cx[4]) - EW'(cx[5]);
    ez_nxt[2] = EW'(cz[4]) - EW'(cz[5]);
    ex_nxt[3] = EW'(cx[4]) - EW'(cx[7]);
    ez_nxt[3] = EW'(cz[4]) - EW'(cz[7]);
    dx_nxt    = (DW'(cx[4]) + DW'(cx[6])) - (DW'(cx[0]) + DW'(cx[2]));
    dz_nxt    = (DW'(cz[4]) + DW'(cz[6])) - (DW'(cz[0]) + DW'(cz[2]));
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 4; k++) begin
        ex_r[k] <= ex_nxt[k];
        ez_r[k] <= ez_nxt[k];
      end
      dx_r <= dx_nxt;
      dz_r <= dz_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products. Per axis: d.e and e.e; crosses between the edges of
  // rectangle 1 (i) and rectangle 2 (j) are shared by both rectangles' axes.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pdx_nxt [4];
  logic signed [PW-1:0] pdz_nxt [4];
  logic signed [PW-1:0] psx_nxt [4];
  logic signed [PW-1:0] psz_nxt [4];
  logic signed [PW-1:0] pcx_nxt [2][2];
  logic signed [PW-1:0] pcz_nxt [2][2];
  logic signed [PW-1:0] pdx_r [4];
  logic signed [PW-1:0] pdz_r [4];
  logic signed [PW-1:0] psx_r [4];
  logic signed [PW-1:0] psz_r [4];
  logic signed [PW-1:0] pcx_r [2][2];
  logic signed [PW-1:0] pcz_r [2][2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pdx_nxt[k] = PW'(dx_r) * PW'(ex_r[k]);
      pdz_nxt[k] = PW'(dz_r) * PW'(ez_r[k]);
      psx_nxt[k] = PW'(ex_r[k]) * PW'(ex_r[k]);
      psz_nxt[k] = PW'(ez_r[k]) * PW'(ez_r[k]);
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        pcx_nxt[i][j] = PW'(ex_r[i]) * PW'(ex_r[2+j]);
        pcz_nxt[i][j] = PW'(ez_r[i]) * PW'(ez_r[2+j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pdx_r <= pdx_nxt;
      pdz_r <= pdz_nxt;
      psx_r <= psx_nxt;
      psz_r <= psz_nxt;
      pcx_r <= pcx_nxt;
      pcz_r <= pcz_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot products and their magnitudes
  // ---------------------------------------------------------------------------
  logic signed [DTW-1:0] dd_dot [4];
  logic signed [DTW-1:0] sq_dot [4];
  logic signed [DTW-1:0] cr_dot [2][2];
  logic [DTW-1:0] lhs_nxt [4];
  logic [DTW-1:0] sq_nxt  [4];
  logic [DTW-1:0] cr_nxt  [2][2];
  logic [DTW-1:0] lhs_r [4];
  logic [DTW-1:0] sq_r  [4];
  logic [DTW-1:0] cr_r  [2][2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dd_dot[k]  = DTW'(pdx_r[k]) + DTW'(pdz_r[k]);
      sq_dot[k]  = DTW'(psx_r[k]) + DTW'(psz_r[k]);
      lhs_nxt[k] = dd_dot[k][DTW-1] ? DTW'(-dd_dot[k]) : DTW'(dd_dot[k]);
      // sum of squares is never negative
      sq_nxt[k]  = DTW'(sq_dot[k]);
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        cr_dot[i][j] = DTW'(pcx_r[i][j]) + DTW'(pcz_r[i][j]);
        cr_nxt[i][j] = cr_dot[i][j][DTW-1] ? DTW'(-cr_dot[i][j]) : DTW'(cr_dot[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      lhs_r <= lhs_nxt;
      sq_r  <= sq_nxt;
      cr_r  <= cr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: axis compares; equality counts as overlap
  // ---------------------------------------------------------------------------
  logic [SW-1:0] rhs [4];
  logic [3:0]    sep;
  logic          overlap_nxt;
  logic          overlap_r;

  always_comb begin
    rhs[0] = SW'(sq_r[0]) + SW'(cr_r[0][0]) + SW'(cr_r[0][1]);
    rhs[1] = SW'(sq_r[1]) + SW'(cr_r[1][0]) + SW'(cr_r[1][1]);
    rhs[2] = SW'(sq_r[2]) + SW'(cr_r[0][0]) + SW'(cr_r[1][0]);
    rhs[3] = SW'(sq_r[3]) + SW'(cr_r[0][1]) + SW'(cr_r[1][1]);
    for (int k = 0; k < 4; k++) begin
      sep[k] = SW'(lhs_r[k]) > rhs[k];
    end
    overlap_nxt = ~|sep;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_tdata = {(obbot_pkg::OUT_TDATA_WIDTH-1)'(0), overlap_r};

endmodule

// File: design/obbot_chk.sv
module obbot_chk #(
  parameter int unsigned COORD_WIDTH = obbot_pkg::COORD_WIDTH
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [obbot_pkg::NUM_CORNERS*2*COORD_WIDTH-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [obbot_pkg::OUT_TDATA_WIDTH-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input backpressure only when the pipeline is full behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // zero fill above the overlap bit
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[obbot_pkg::OUT_TDATA_WIDTH-1:1] == '0)
    else $error("result padding not zero");

  // an input accepted into an empty pipeline reaches the output valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && $past(!in_tvalid, 1)
      && $past(!in_tvalid, 2) && $past(!in_tvalid, 3) && $past(rst_n, 3)
      |=> ##3 out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind obb_overlap_test_2d obbot_chk #(.COORD_WIDTH(COORD_WIDTH)) u_obbot_chk (.*);
